// ----- rtl/expnp_pkg.sv -----
`default_nettype none

package expnp_pkg;

    localparam int OP_LAT = 3;
    localparam int NSTG   = 11 * OP_LAT;

    localparam logic [31:0] K_LOG2E_X64 = 32'h42B8AA3B;
    localparam logic [31:0] K_BIAS      = 32'h4B400000;
    localparam logic [31:0] K_NEG_BIAS  = 32'hCB400000;
    localparam logic [31:0] K_NLN2_HI   = 32'hBC318000;
    localparam logic [31:0] K_NLN2_LO   = 32'h365E8083;
    localparam logic [31:0] K_C2        = 32'h3EFFFF85;
    localparam logic [30:0] K_CUT_MAG   = 31'h42AEAC4F;
    localparam logic [30:0] K_INF_MAG   = 31'h7F800000;
    localparam logic [31:0] K_QNAN      = 32'hFFC00000;
    localparam logic [31:0] K_QBIT      = 32'h00400000;

    function automatic logic [31:0] pow2_frac(input logic [5:0] idx);
        logic [31:0] r;
        case (idx)
            6'd0:  r = 32'h3F800000;  6'd1:  r = 32'h3F8164D2;
            6'd2:  r = 32'h3F82CD87;  6'd3:  r = 32'h3F843A29;
            6'd4:  r = 32'h3F85AAC3;  6'd5:  r = 32'h3F871F62;
            6'd6:  r = 32'h3F88980F;  6'd7:  r = 32'h3F8A14D5;
            6'd8:  r = 32'h3F8B95C2;  6'd9:  r = 32'h3F8D1ADF;
            6'd10: r = 32'h3F8EA43A;  6'd11: r = 32'h3F9031DC;
            6'd12: r = 32'h3F91C3D3;  6'd13: r = 32'h3F935A2B;
            6'd14: r = 32'h3F94F4F0;  6'd15: r = 32'h3F96942D;
            6'd16: r = 32'h3F9837F0;  6'd17: r = 32'h3F99E046;
            6'd18: r = 32'h3F9B8D3A;  6'd19: r = 32'h3F9D3EDA;
            6'd20: r = 32'h3F9EF532;  6'd21: r = 32'h3FA0B051;
            6'd22: r = 32'h3FA27043;  6'd23: r = 32'h3FA43516;
            6'd24: r = 32'h3FA5FED7;  6'd25: r = 32'h3FA7CD94;
            6'd26: r = 32'h3FA9A15B;  6'd27: r = 32'h3FAB7A3A;
            6'd28: r = 32'h3FAD583F;  6'd29: r = 32'h3FAF3B79;
            6'd30: r = 32'h3FB123F6;  6'd31: r = 32'h3FB311C4;
            6'd32: r = 32'h3FB504F3;  6'd33: r = 32'h3FB6FD92;
            6'd34: r = 32'h3FB8FBAF;  6'd35: r = 32'h3FBAFF5B;
            6'd36: r = 32'h3FBD08A4;  6'd37: r = 32'h3FBF179A;
            6'd38: r = 32'h3FC12C4D;  6'd39: r = 32'h3FC346CD;
            6'd40: r = 32'h3FC5672A;  6'd41: r = 32'h3FC78D75;
            6'd42: r = 32'h3FC9B9BE;  6'd43: r = 32'h3FCBEC15;
            6'd44: r = 32'h3FCE248C;  6'd45: r = 32'h3FD06334;
            6'd46: r = 32'h3FD2A81E;  6'd47: r = 32'h3FD4F35B;
            6'd48: r = 32'h3FD744FD;  6'd49: r = 32'h3FD99D16;
            6'd50: r = 32'h3FDBFBB8;  6'd51: r = 32'h3FDE60F5;
            6'd52: r = 32'h3FE0CCDF;  6'd53: r = 32'h3FE33F89;
            6'd54: r = 32'h3FE5B907;  6'd55: r = 32'h3FE8396A;
            6'd56: r = 32'h3FEAC0C7;  6'd57: r = 32'h3FED4F30;
            6'd58: r = 32'h3FEFE4BA;  6'd59: r = 32'h3FF28177;
            6'd60: r = 32'h3FF5257D;  6'd61: r = 32'h3FF7D0DF;
            6'd62: r = 32'h3FFA83B3;  6'd63: r = 32'h3FFD3E0C;
            default: r = 32'h3F800000;
        endcase
        return r;
    endfunction

    // leading zero count, 48 when all zero
    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] lz;
        lz = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                lz = 6'(47 - i);
            end
        end
        return lz;
    endfunction

    // sig: leading one at bit 26, bits [2:0] guard/round/sticky; exp biased
    function automatic logic [31:0] round_pack(input logic sign,
                                               input logic signed [11:0] exp,
                                               input logic [26:0] sig);
        logic [26:0] ss;
        logic [26:0] shifted;
        logic [4:0] sh;
        logic st;
        logic signed [11:0] e;
        logic [23:0] mant;
        logic rup;
        logic [30:0] word;
        ss = sig;
        e = exp;
        sh = 5'd0;
        if (exp < 12'sd1) begin
            if (exp < -12'sd25) begin
                sh = 5'd27;
            end else begin
                sh = 5'(12'sd1 - exp);
            end
            shifted = sig >> sh;
            st = |(sig & ~({27{1'b1}} << sh));
            ss = {shifted[26:1], shifted[0] | st};
            e = 12'sd1;
        end
        mant = ss[26:3];
        rup = ss[2] & ((|ss[1:0]) | mant[0]);
        word = {8'(e - 12'sd1), 23'd0} + {7'd0, mant} + {30'd0, rup};
        if (e > 12'sd254) begin
            return {sign, 8'hFF, 23'd0};
        end
        return {sign, word};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/expnp_fmul.sv -----
`default_nettype none

module expnp_fmul
    import expnp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic [2:0]  en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [31:0]      y
);

    logic [7:0]  ea, eb, eae, ebe;
    logic [23:0] ma, mb;
    logic        anan, bnan, ainf, binf, azero, bzero, sgn;
    logic        spec_next;
    logic [31:0] spval_next;

    logic [47:0]        prod_reg;
    logic signed [11:0] exp1_reg;
    logic               sgn1_reg, spec1_reg;
    logic [31:0]        spval1_reg;

    logic [5:0]         lz;
    logic [47:0]        norm;
    logic [26:0]        sig2_reg;
    logic signed [11:0] exp2_reg;
    logic               sgn2_reg, spec2_reg;
    logic [31:0]        spval2_reg;

    always_comb begin
        ea = a[30:23];
        eb = b[30:23];
        ma = {|ea, a[22:0]};
        mb = {|eb, b[22:0]};
        eae = (ea == 8'd0) ? 8'd1 : ea;
        ebe = (eb == 8'd0) ? 8'd1 : eb;
        anan = (ea == 8'hFF) && (a[22:0] != 23'd0);
        bnan = (eb == 8'hFF) && (b[22:0] != 23'd0);
        ainf = (ea == 8'hFF) && (a[22:0] == 23'd0);
        binf = (eb == 8'hFF) && (b[22:0] == 23'd0);
        azero = (a[30:0] == 31'd0);
        bzero = (b[30:0] == 31'd0);
        sgn = a[31] ^ b[31];
        spec_next = 1'b1;
        if (anan) begin
            spval_next = a | K_QBIT;
        end else if (bnan) begin
            spval_next = b | K_QBIT;
        end else if ((ainf && bzero) || (binf && azero)) begin
            spval_next = K_QNAN;
        end else if (ainf || binf) begin
            spval_next = {sgn, 8'hFF, 23'd0};
        end else if (azero || bzero) begin
            spval_next = {sgn, 31'd0};
        end else begin
            spec_next = 1'b0;
            spval_next = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg   <= ma * mb;
            exp1_reg   <= $signed({4'd0, eae}) + $signed({4'd0, ebe}) - 12'sd127;
            sgn1_reg   <= sgn;
            spec1_reg  <= spec_next;
            spval1_reg <= spval_next;
        end
    end

    always_comb begin
        lz = lzc48(prod_reg);
        norm = prod_reg << lz;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sig2_reg   <= {norm[47:22], |norm[21:0]};
            exp2_reg   <= exp1_reg + 12'sd1 - $signed({6'd0, lz});
            sgn2_reg   <= sgn1_reg;
            spec2_reg  <= spec1_reg;
            spval2_reg <= spval1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            y <= spec2_reg ? spval2_reg : round_pack(sgn2_reg, exp2_reg, sig2_reg);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/expnp_fadd.sv -----
`default_nettype none

module expnp_fadd
    import expnp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic [2:0]  en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [31:0]      y
);

    logic [31:0] big, sml;
    logic [7:0]  ebg, esm, ebge, esme, d;
    logic [26:0] sm, shifted, sml_al;
    logic        st;
    logic        anan, bnan, ainf, binf;
    logic        spec_next;
    logic [31:0] spval_next;

    logic [26:0] big1_reg, small1_reg;
    logic [7:0]  exp1_reg;
    logic        sub1_reg, sgn1_reg, zsgn1_reg, spec1_reg;
    logic [31:0] spval1_reg;

    logic [27:0] sum;
    logic [27:0] sum2_reg;
    logic [5:0]  lz2_reg;
    logic [7:0]  exp2_reg;
    logic        sgn2_reg, zsgn2_reg, spec2_reg;
    logic [31:0] spval2_reg;

    logic [27:0]        norm;
    logic signed [11:0] nexp;

    always_comb begin
        if (a[30:0] >= b[30:0]) begin
            big = a;
            sml = b;
        end else begin
            big = b;
            sml = a;
        end
        ebg = big[30:23];
        esm = sml[30:23];
        ebge = (ebg == 8'd0) ? 8'd1 : ebg;
        esme = (esm == 8'd0) ? 8'd1 : esm;
        d = ebge - esme;
        sm = {|esm, sml[22:0], 3'd0};
        if (d >= 8'd27) begin
            shifted = 27'd0;
            st = |sm;
        end else begin
            shifted = sm >> d[4:0];
            st = |(sm & ~({27{1'b1}} << d[4:0]));
        end
        sml_al = {shifted[26:1], shifted[0] | st};

        anan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        bnan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ainf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        binf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        spec_next = 1'b1;
        if (anan) begin
            spval_next = a | K_QBIT;
        end else if (bnan) begin
            spval_next = b | K_QBIT;
        end else if (ainf && binf && (a[31] != b[31])) begin
            spval_next = K_QNAN;
        end else if (ainf) begin
            spval_next = a;
        end else if (binf) begin
            spval_next = b;
        end else begin
            spec_next = 1'b0;
            spval_next = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            big1_reg   <= {|ebg, big[22:0], 3'd0};
            small1_reg <= sml_al;
            exp1_reg   <= ebge;
            sub1_reg   <= a[31] ^ b[31];
            sgn1_reg   <= big[31];
            zsgn1_reg  <= a[31] & b[31];
            spec1_reg  <= spec_next;
            spval1_reg <= spval_next;
        end
    end

    always_comb begin
        if (sub1_reg) begin
            sum = {1'b0, big1_reg} - {1'b0, small1_reg};
        end else begin
            sum = {1'b0, big1_reg} + {1'b0, small1_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sum2_reg   <= sum;
            lz2_reg    <= lzc48({sum, 20'd0});
            exp2_reg   <= exp1_reg;
            sgn2_reg   <= sgn1_reg;
            zsgn2_reg  <= zsgn1_reg;
            spec2_reg  <= spec1_reg;
            spval2_reg <= spval1_reg;
        end
    end

    always_comb begin
        norm = sum2_reg << lz2_reg;
        nexp = $signed({4'd0, exp2_reg}) + 12'sd1 - $signed({6'd0, lz2_reg});
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            if (spec2_reg) begin
                y <= spval2_reg;
            end else if (sum2_reg == 28'd0) begin
                y <= {zsgn2_reg, 31'd0};
            end else begin
                y <= round_pack(sgn2_reg, nexp, {norm[27:2], |norm[1:0]});
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/exp_nonpositive_f32.sv -----
// Structure: 11 float operations in sequence, 3 register stages each:
// multiply or align, normalize, round.
// Throughput: one request per cycle unless m_tready back-pressure has
// filled every stage; stages advance independently, so bubbles close up
// while the output is stalled.
// Reset: aresetn low at a clock edge clears all stage valid bits.
`default_nettype none

module exp_nonpositive_f32
    import expnp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] x_bits
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] y_bits
    output logic             m_tlast
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] tmp2;
        logic        last;
        logic        cut;
    } side_t;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] adv;
    side_t           side_reg  [NSTG];
    side_t           side_next [NSTG];

    logic [31:0] prod, biased, n, tmp1, tmp2, t1, t, p1, p2, p3, y1, y;
    logic [31:0] scale;

    always_comb begin
        adv[NSTG-1] = !valid_reg[NSTG-1] || m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[NSTG-1];
    assign m_tlast  = side_reg[NSTG-1].last;
    assign m_tdata  = side_reg[NSTG-1].cut ? 32'd0 : y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign scale = pow2_frac(biased[5:0]) + {biased[14:6], 23'd0};

    always_comb begin
        for (int i = 0; i < NSTG; i++) begin
            if (i == 0) begin
                side_next[i].x    = s_tdata;
                side_next[i].s    = 32'd0;
                side_next[i].t    = 32'd0;
                side_next[i].tmp2 = 32'd0;
                side_next[i].last = s_tlast;
                side_next[i].cut  = s_tdata[31] && (s_tdata[30:0] > K_CUT_MAG)
                                    && (s_tdata[30:0] <= K_INF_MAG);
            end else begin
                side_next[i] = side_reg[i-1];
            end
            if (i == 2 * OP_LAT) begin
                side_next[i].s = scale;
            end
            if (i == 4 * OP_LAT) begin
                side_next[i].tmp2 = tmp2;
            end
            if (i == 6 * OP_LAT) begin
                side_next[i].t = t;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NSTG; i++) begin
            if (adv[i]) begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    expnp_fmul u_prod (.aclk, .en(adv[2:0]), .a(s_tdata), .b(K_LOG2E_X64), .y(prod));
    expnp_fadd u_bias (.aclk, .en(adv[5:3]), .a(prod), .b(K_BIAS), .y(biased));
    expnp_fadd u_unbias (.aclk, .en(adv[8:6]), .a(biased), .b(K_NEG_BIAS), .y(n));
    expnp_fmul u_hi (.aclk, .en(adv[11:9]), .a(n), .b(K_NLN2_HI), .y(tmp1));
    expnp_fmul u_lo (.aclk, .en(adv[11:9]), .a(n), .b(K_NLN2_LO), .y(tmp2));
    expnp_fadd u_t1 (.aclk, .en(adv[14:12]), .a(tmp1), .b(side_reg[11].x), .y(t1));
    expnp_fadd u_t (.aclk, .en(adv[17:15]), .a(side_reg[14].tmp2), .b(t1), .y(t));
    expnp_fmul u_p1 (.aclk, .en(adv[20:18]), .a(t), .b(K_C2), .y(p1));
    expnp_fmul u_p2 (.aclk, .en(adv[23:21]), .a(p1), .b(side_reg[20].t), .y(p2));
    expnp_fadd u_p3 (.aclk, .en(adv[26:24]), .a(p2), .b(side_reg[23].t), .y(p3));
    expnp_fmul u_y1 (.aclk, .en(adv[29:27]), .a(p3), .b(side_reg[26].s), .y(y1));
    expnp_fadd u_y (.aclk, .en(adv[32:30]), .a(y1), .b(side_reg[29].s), .y(y));

endmodule

`default_nettype wire

// ----- rtl/expnp_chk.sv -----
`default_nettype none

module expnp_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with free output");

    a_nan_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != 23'd0) |-> m_tdata[22])
        else $error("signaling NaN on output");

    a_stall_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

endmodule

bind exp_nonpositive_f32 expnp_chk u_chk (.*);

`default_nettype wire
